[hw/rtl/nearest_centroid_hour_anomaly_assert.svh]
// ----------------------------------------------------------------------------
// nearest_centroid_hour_anomaly_assert.svh
// assertion macros for the nearest centroid hour anomaly detector
// ----------------------------------------------------------------------------
`ifndef NEAREST_CENTROID_HOUR_ANOMALY_ASSERT_SVH
`define NEAREST_CENTROID_HOUR_ANOMALY_ASSERT_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define NCA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("nca assertion failed");

// property checked on every clock edge, reset included
`define NCA_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("nca assertion failed");

`else

`define NCA_ASSERT(label, clk, rst, prop)
`define NCA_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[hw/rtl/nca_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_pkg
// types and constants shared by the nearest centroid hour anomaly detector
// ----------------------------------------------------------------------------
package nca_pkg;

   localparam int FRAC_BITS     = 8;
   localparam int HOUR_W        = 5;
   localparam int ENTRY_IDX_W   = 4;
   localparam int CENTER_W      = 13;
   localparam int SPREAD_W      = 16;
   localparam int THRESH_W      = 12;
   localparam int CENTERS_W     = 5;
   localparam int DIST_W        = 12;
   localparam int CLUSTER_W     = 4;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 12;
   localparam int PROD_W        = THRESH_W + SPREAD_W;

   localparam logic [CENTER_W-1:0] DAY_LEN        = CENTER_W'(24 << FRAC_BITS);
   localparam logic [DIST_W-1:0]   HALF_DAY       = DIST_W'(12 << FRAC_BITS);
   localparam logic [DIST_W-1:0]   ONE_HOUR       = DIST_W'(1 << FRAC_BITS);
   localparam logic [HOUR_W-1:0]   HOURS_PER_DAY  = HOUR_W'(24);
   localparam logic [THRESH_W-1:0] THRESHOLD_RESET = THRESH_W'(7 << (FRAC_BITS - 2));

   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTERS_IN_USE = 1'b1;

   typedef enum logic {
      OP_CLASSIFY = 1'b0,
      OP_WRITE    = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_MUL,
      ST_CMP
   } state_type;

   typedef struct packed {
      op_type                 operation;
      logic [HOUR_W-1:0]      hour;
      logic [ENTRY_IDX_W-1:0] entry_index;
      logic [CENTER_W-1:0]    entry_center;
      logic [SPREAD_W-1:0]    entry_spread;
   } req_type;

   typedef struct packed {
      logic                 anomaly;
      logic [CLUSTER_W-1:0] nearest_cluster;
      logic [DIST_W-1:0]    nearest_distance;
   } rsp_type;

endpackage

[hw/rtl/nca_dist_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_dist_unit
// circular distance between a stored centre and the event hour on a 24-hour day
// ----------------------------------------------------------------------------
module nca_dist_unit
   import nca_pkg::*;
(
   input  logic [CENTER_W-1:0] center,
   input  logic [CENTER_W-1:0] event_hour,
   output logic [DIST_W-1:0]   distance
);

   logic [CENTER_W-1:0] center_mod;
   logic [CENTER_W-1:0] diff;
   logic [CENTER_W-1:0] wrap;

   always_comb begin
      // stored centre is below two days, one subtract folds it
      center_mod = (center >= DAY_LEN) ? center - DAY_LEN : center;
      diff       = (center_mod > event_hour) ? center_mod - event_hour
                                             : event_hour - center_mod;
      wrap       = DAY_LEN - diff;
      distance   = (diff < wrap) ? DIST_W'(diff) : DIST_W'(wrap);
   end

endmodule

[hw/rtl/nearest_centroid_hour_anomaly.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_centroid_hour_anomaly
// nearest centroid anomaly detector for event hours on a 24-hour circle
// ----------------------------------------------------------------------------
// A write transaction stores one centre (Q5.8 hours) and spread (Q8.8) in the
// table. A classify transaction walks the first centers_in_use entries
// (clamped to MAX_CENTERS) through one distance and compare unit, one centre
// per cycle behind the registered table read, then runs one multiply and one
// compare for the threshold test; req_stall is high for that whole search,
// longer while the previous result still waits in the output register. A
// classify with no centres in use gives no result. The table holds garbage
// after reset; every entry that is searched must have been written first.
// One result waits in the output register, so the next transaction is
// accepted while the previous result is still stalled.
// ----------------------------------------------------------------------------
`include "nearest_centroid_hour_anomaly_assert.svh"

module nearest_centroid_hour_anomaly
   import nca_pkg::*;
#(
   parameter int MAX_CENTERS = 16
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,

   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
   localparam int CNT_W = $clog2(MAX_CENTERS + 1);

   // configuration
   logic [THRESH_W-1:0]  threshold_ff;
   logic [CENTERS_W-1:0] centers_ff;

   // sequencer
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     scan_ff;
   logic [CENTER_W-1:0]  event_ff, event_in;
   logic [HOUR_W-1:0]    hour_mod;

   // table
   logic [CENTER_W-1:0]  center_mem [MAX_CENTERS];
   logic [SPREAD_W-1:0]  spread_mem [MAX_CENTERS];
   logic [IDX_W-1:0]     wr_addr;
   logic [IDX_W-1:0]     rd_addr;

   // scan pipeline
   logic                 rd_vld_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic [CENTER_W-1:0]  center_rd_ff;
   logic [SPREAD_W-1:0]  spread_rd_ff;
   logic [DIST_W-1:0]    dist_comb;
   logic                 dist_vld_ff;
   logic [DIST_W-1:0]    dist_ff;
   logic [IDX_W-1:0]     dist_idx_ff;
   logic [SPREAD_W-1:0]  dist_spread_ff;
   logic                 best_any_ff;
   logic [DIST_W-1:0]    best_d_ff;
   logic [IDX_W-1:0]     best_idx_ff;
   logic [SPREAD_W-1:0]  best_spread_ff;
   logic                 best_upd;
   logic [PROD_W-1:0]    prod_ff;
   logic                 anomaly_comb;

   // output register
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   // control
   logic                 req_accept;
   logic                 start;
   logic                 mem_wr;
   logic                 issue;
   logic                 out_load;

   // ------------------------------------------------------------------------
   // configuration port
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         centers_ff   <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_THRESHOLD:      threshold_ff <= csr_wdata;
            CSR_CENTERS_IN_USE: centers_ff   <= csr_wdata[CENTERS_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // sequencer outputs
   // ------------------------------------------------------------------------
   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      req_accept = req_valid && !req_stall;
      start      = req_accept && (req_data.operation == OP_CLASSIFY)
                   && (centers_ff != '0);
      mem_wr     = req_accept && (req_data.operation == OP_WRITE)
                   && (int'(req_data.entry_index) < MAX_CENTERS);
      issue      = (state_ff == ST_SCAN) && (scan_ff < count_ff);
      out_load   = (state_ff == ST_CMP) && (!rsp_valid_ff || !rsp_stall);
   end

   // ------------------------------------------------------------------------
   // sequencer next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (start) state_in = ST_SCAN;
         ST_SCAN:  if (scan_ff == count_ff) state_in = ST_DRAIN;
         ST_DRAIN: if (!rd_vld_ff && !dist_vld_ff) state_in = ST_MUL;
         ST_MUL:   state_in = ST_CMP;
         ST_CMP:   if (out_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      hour_mod = (req_data.hour >= HOURS_PER_DAY) ? req_data.hour - HOURS_PER_DAY
                                                  : req_data.hour;
      event_in = CENTER_W'(hour_mod) << FRAC_BITS;
      if (int'(centers_ff) > MAX_CENTERS) begin
         count_in = CNT_W'(MAX_CENTERS);
      end else begin
         count_in = CNT_W'(centers_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (start) begin
            scan_ff  <= '0;
            count_ff <= count_in;
         end else if (issue) begin
            scan_ff <= scan_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         event_ff <= event_in;
      end
   end

   // ------------------------------------------------------------------------
   // centre and spread table
   // ------------------------------------------------------------------------
   assign wr_addr = IDX_W'(req_data.entry_index);
   assign rd_addr = scan_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         center_mem[wr_addr] <= req_data.entry_center;
         spread_mem[wr_addr] <= req_data.entry_spread;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         center_rd_ff <= center_mem[rd_addr];
         spread_rd_ff <= spread_mem[rd_addr];
         rd_idx_ff    <= rd_addr;
      end
   end

   // ------------------------------------------------------------------------
   // distance and running minimum
   // ------------------------------------------------------------------------
   nca_dist_unit u_dist (
      .center     (center_rd_ff),
      .event_hour (event_ff),
      .distance   (dist_comb)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         dist_vld_ff <= 1'b0;
         best_any_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= issue;
         dist_vld_ff <= rd_vld_ff;
         if (start) begin
            best_any_ff <= 1'b0;
         end else if (dist_vld_ff) begin
            best_any_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         dist_ff        <= dist_comb;
         dist_idx_ff    <= rd_idx_ff;
         dist_spread_ff <= spread_rd_ff;
      end
   end

   // strict less-than keeps the lowest index on ties
   assign best_upd = dist_vld_ff && (!best_any_ff || (dist_ff < best_d_ff));

   always_ff @(posedge clock) begin
      if (best_upd) begin
         best_d_ff      <= dist_ff;
         best_idx_ff    <= dist_idx_ff;
         best_spread_ff <= dist_spread_ff;
      end
   end

   // ------------------------------------------------------------------------
   // threshold test: dist << frac >= threshold * spread, or dist >= one hour for zero spread
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         prod_ff <= PROD_W'(threshold_ff) * PROD_W'(best_spread_ff);
      end
   end

   always_comb begin
      if (best_spread_ff != '0) begin
         anomaly_comb = ((PROD_W'(best_d_ff) << FRAC_BITS) >= prod_ff);
      end else begin
         anomaly_comb = (best_d_ff >= ONE_HOUR);
      end
   end

   // ------------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff.anomaly          <= anomaly_comb;
         rsp_data_ff.nearest_cluster  <= CLUSTER_W'(best_idx_ff);
         rsp_data_ff.nearest_distance <= best_d_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   `NCA_ASSERT(a_scan_in_range, clock, reset, scan_ff <= count_ff)
   `NCA_ASSERT(a_best_in_range, clock, reset,
               (state_ff == ST_MUL) |-> (CNT_W'(best_idx_ff) < count_ff))
   `NCA_ASSERT(a_load_shows, clock, reset, out_load |=> rsp_valid)
   `NCA_ASSERT_ALWAYS(a_dist_bound, clock,
                      rsp_valid_ff |-> (rsp_data_ff.nearest_distance <= HALF_DAY))

endmodule

[test/tb_nearest_centroid_hour_anomaly.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_centroid_hour_anomaly
// self-checking bench for the nearest centroid hour anomaly detector
// ----------------------------------------------------------------------------
// Table writes and hour events are queued by the stimulus process and sent by
// a bursty driver. Every accepted transaction runs through a scoring function
// that keeps its own copy of the centre and spread tables and the two
// registers, and each expected verdict is checked against the result channel
// in order. The registers change only between phases, once the block has
// gone quiet. A directed opening covers the boundaries; random phases with
// varied thresholds and centre counts follow.
// ----------------------------------------------------------------------------
module tb_nearest_centroid_hour_anomaly;
   import nca_pkg::*;

   localparam int TABLE_DEPTH    = 16;
   localparam int DAY_TICKS      = 24 << FRAC_BITS;
   localparam int RANDOM_EVENTS  = 1500;
   localparam int SETTLE_CYCLES  = 40;
   localparam int DRAIN_LIMIT    = 1000;
   // longest quiet stretch: a driver gap, a full search and an output stall
   localparam int WATCHDOG_LIMIT = 2000;

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_stall;
   req_type                req_data     = '0;
   logic                   rsp_valid;
   logic                   rsp_stall    = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = CSR_THRESHOLD;
   logic [CSR_DATA_W-1:0]  csr_wdata    = '0;

   // register and table copies used for scoring
   logic [THRESH_W-1:0]  cur_threshold = THRESHOLD_RESET;
   logic [CENTERS_W-1:0] cur_centers   = '0;
   logic [CENTER_W-1:0]  center_copy [TABLE_DEPTH];
   logic [SPREAD_W-1:0]  spread_copy [TABLE_DEPTH];

   req_type     event_queue[$];
   rsp_type     pending_verdicts[$];
   int unsigned queued_events   = 0;
   int unsigned accepted_events = 0;
   int unsigned mismatch_count  = 0;
   int unsigned random_events   = 0;
   logic [TABLE_DEPTH-1:0] filled_entries = '0;

   bit          tx_quiet = 1'b0;
   bit          rx_quiet = 1'b0;
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;
   int unsigned rx_run     = 0;
   int unsigned idle_count = 0;

   nearest_centroid_hour_anomaly u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #4 clock = ~clock;

   task automatic flag_mismatch(input string what, input int unsigned want,
                                input int unsigned got);
      $display("mismatch: %s expected %0d got %0d", what, want, got);
      mismatch_count++;
   endtask

   // table update or nearest-centre search for one accepted transaction
   function automatic void score_event(input req_type item);
      int unsigned searched, event_pos, center_pos, gap, span;
      int unsigned best_dist, best_idx, prod, i;
      rsp_type     verdict;
      if (item.operation == OP_WRITE) begin
         center_copy[item.entry_index] = item.entry_center;
         spread_copy[item.entry_index] = item.entry_spread;
         return;
      end
      searched = (cur_centers > TABLE_DEPTH) ? TABLE_DEPTH : cur_centers;
      if (searched == 0)
         return;
      event_pos = (int'(item.hour) % 24) << FRAC_BITS;
      best_dist = 0;
      best_idx  = 0;
      for (i = 0; i < searched; i++) begin
         center_pos = int'(center_copy[i]) % DAY_TICKS;
         gap  = (center_pos > event_pos) ? center_pos - event_pos : event_pos - center_pos;
         span = (gap < DAY_TICKS - gap) ? gap : DAY_TICKS - gap;
         if (i == 0 || span < best_dist) begin
            best_dist = span;
            best_idx  = i;
         end
      end
      prod = cur_threshold * spread_copy[best_idx];
      verdict.nearest_cluster  = CLUSTER_W'(best_idx);
      verdict.nearest_distance = DIST_W'(best_dist);
      if (spread_copy[best_idx] != 0)
         verdict.anomaly = ((best_dist << FRAC_BITS) >= prod);
      else
         verdict.anomaly = (best_dist >= (1 << FRAC_BITS));
      pending_verdicts.insert(pending_verdicts.size(), verdict);
   endfunction

   // driver: bursts of transactions with random gaps, payload held while stalled
   always @(posedge clock) begin
      logic    next_valid;
      req_type next_item;
      if (reset) begin
         req_valid  <= 1'b0;
         req_data   <= '0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         next_valid = req_valid;
         next_item  = req_data;
         if (req_valid && !req_stall) begin
            score_event(req_data);
            accepted_events++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (event_queue.size() != 0) begin
               next_item  = event_queue.pop_front();
               next_valid = 1'b1;
               if (burst_left != 0) begin
                  burst_left--;
               end else if (!tx_quiet) begin
                  burst_left = $urandom_range(0, 19);
                  gap_left   = $urandom_range(1, 12);
               end
            end
         end
         req_valid <= next_valid;
         req_data  <= next_item;
      end
   end

   // receiver stall pattern: alternating runs of random length
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_run    = 0;
      end else if (rx_quiet) begin
         rsp_stall <= 1'b0;
      end else if (rx_run != 0) begin
         rx_run--;
      end else begin
         rsp_stall <= ~rsp_stall;
         rx_run    = rsp_stall ? $urandom_range(0, 9) : $urandom_range(0, 7);
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            flag_mismatch("unexpected result, cluster", 0, rsp_data.nearest_cluster);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_data.anomaly !== want.anomaly)
               flag_mismatch("anomaly", want.anomaly, rsp_data.anomaly);
            if (rsp_data.nearest_cluster !== want.nearest_cluster)
               flag_mismatch("nearest_cluster", want.nearest_cluster,
                             rsp_data.nearest_cluster);
            if (rsp_data.nearest_distance !== want.nearest_distance)
               flag_mismatch("nearest_distance", want.nearest_distance,
                             rsp_data.nearest_distance);
         end
      end
   end

   initial begin
      while (idle_count < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_write_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_count = 0;
         else
            idle_count++;
      end
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_nearest_centroid_hour_anomaly failed");
      $finish;
   end

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input int unsigned value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_THRESHOLD)
         cur_threshold = value[THRESH_W-1:0];
      else
         cur_centers = value[CENTERS_W-1:0];
   endtask

   task automatic push_write(input int unsigned idx, input int unsigned center,
                             input int unsigned spread);
      req_type item;
      item.operation    = OP_WRITE;
      item.hour         = HOUR_W'($urandom);
      item.entry_index  = ENTRY_IDX_W'(idx);
      item.entry_center = CENTER_W'(center);
      item.entry_spread = SPREAD_W'(spread);
      event_queue.insert(event_queue.size(), item);
      filled_entries[idx] = 1'b1;
      queued_events++;
   endtask

   // unused fields of a classify carry random junk
   task automatic push_classify(input int unsigned hour);
      req_type item;
      item.operation    = OP_CLASSIFY;
      item.hour         = HOUR_W'(hour);
      item.entry_index  = ENTRY_IDX_W'($urandom);
      item.entry_center = CENTER_W'($urandom);
      item.entry_spread = SPREAD_W'($urandom);
      event_queue.insert(event_queue.size(), item);
      queued_events++;
   endtask

   // wait for the block to go quiet before touching the registers
   task automatic wait_quiet();
      int unsigned waited;
      rsp_type     left;
      waited = 0;
      while (accepted_events != queued_events)
         @(posedge clock);
      while (pending_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      while (pending_verdicts.size() != 0) begin
         left = pending_verdicts.pop_front();
         flag_mismatch("missing result, cluster", left.nearest_cluster, 0);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic int unsigned pick_center();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom_range(0, 31) << FRAC_BITS;
         5:             return $urandom_range(DAY_TICKS, (1 << CENTER_W) - 1);
         default:       return $urandom_range(0, DAY_TICKS - 1);
      endcase
   endfunction

   // spreads: zero, random, small, or aimed near the point where distance equals threshold * spread
   function automatic int unsigned pick_spread();
      int unsigned aim;
      case ($urandom_range(0, 5))
         0: return 0;
         1: return $urandom_range(0, (1 << SPREAD_W) - 1);
         2: return $urandom_range(1, 1023);
         default: begin
            if (cur_threshold == 0)
               return $urandom_range(0, (1 << SPREAD_W) - 1);
            aim = ($urandom_range(0, 12) << (2 * FRAC_BITS)) / cur_threshold;
            aim = aim + $urandom_range(0, 2);
            aim = (aim == 0) ? 0 : aim - 1;
            return (aim > 65535) ? 65535 : aim;
         end
      endcase
   endfunction

   task automatic run_random_phase();
      int unsigned n_events, searched, i;
      case ($urandom_range(0, 6))
         0:       write_csr(CSR_THRESHOLD, 0);
         1:       write_csr(CSR_THRESHOLD, (1 << THRESH_W) - 1);
         2:       write_csr(CSR_THRESHOLD, 1 << FRAC_BITS);
         3:       write_csr(CSR_THRESHOLD, int'(THRESHOLD_RESET));
         4:       write_csr(CSR_THRESHOLD, 2 << FRAC_BITS);
         default: write_csr(CSR_THRESHOLD, $urandom_range(0, (1 << CSR_DATA_W) - 1));
      endcase
      case ($urandom_range(0, 9))
         0:       write_csr(CSR_CENTERS_IN_USE, 1);
         1, 2:    write_csr(CSR_CENTERS_IN_USE, TABLE_DEPTH);
         3:       write_csr(CSR_CENTERS_IN_USE, $urandom_range(TABLE_DEPTH + 1, 31));
         4:       write_csr(CSR_CENTERS_IN_USE, 0);
         default: write_csr(CSR_CENTERS_IN_USE, $urandom_range(2, TABLE_DEPTH - 1));
      endcase
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      n_events = (cur_centers == 0) ? $urandom_range(5, 15) : $urandom_range(40, 110);
      searched = (cur_centers > TABLE_DEPTH) ? TABLE_DEPTH : cur_centers;
      // every searched entry is written before the first classify
      for (i = 0; i < searched; i++) begin
         if (!filled_entries[i])
            push_write(i, pick_center(), pick_spread());
      end
      for (i = 0; i < n_events; i++) begin
         if ($urandom_range(0, 3) == 0)
            push_write($urandom_range(0, TABLE_DEPTH - 1), pick_center(), pick_spread());
         else
            push_classify($urandom_range(0, 31));
      end
      random_events += n_events;
      wait_quiet();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset values: no centres in use, so classify gives nothing
      push_classify(0);
      push_classify(31);
      push_write(0, 0, 0);
      push_write(1, 12 << FRAC_BITS, 1);
      push_write(2, (1 << CENTER_W) - 1, (1 << SPREAD_W) - 1);
      push_write(3, DAY_TICKS - 1, 255);
      push_write(4, 0, 5);
      wait_quiet();

      // two centres 12 hours apart: ties, zero spread, threshold of one
      write_csr(CSR_THRESHOLD, 1 << FRAC_BITS);
      write_csr(CSR_CENTERS_IN_USE, 2);
      push_classify(6);
      push_classify(18);
      push_classify(0);
      push_classify(1);
      push_classify(12);
      push_classify(11);
      wait_quiet();

      // equality of distance and threshold * spread, centre past 24 hours
      write_csr(CSR_CENTERS_IN_USE, 5);
      push_classify(23);
      push_classify(8);
      wait_quiet();

      write_csr(CSR_THRESHOLD, (1 << THRESH_W) - 1);
      push_classify(23);
      push_classify(24);
      push_classify(31);
      push_classify(8);
      wait_quiet();

      while (random_events < RANDOM_EVENTS)
         run_random_phase();

      if (mismatch_count == 0)
         $display("tb_nearest_centroid_hour_anomaly passed");
      else
         $display("tb_nearest_centroid_hour_anomaly failed");
      $finish;
   end

endmodule
